// ----- hdl/hrp_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the hex record parser.
// No dependencies; imported by every module of the block.
package hrp_pkg;

  localparam logic [7:0] CHAR_COLON  = 8'h3A;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] DIGIT_OFS_LOW  = 8'd48;
  localparam logic [7:0] DIGIT_OFS_HIGH = 8'd55;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    BC_LEN    = 3'd0,
    BC_OFS_HI = 3'd1,
    BC_OFS_LO = 3'd2,
    BC_TYPE   = 3'd3,
    BC_DATA   = 3'd4,
    BC_CSUM   = 3'd5
  } byte_class_t;

  typedef enum logic [6:0] {
    PH_IDLE   = 7'b0000001,
    PH_LEN    = 7'b0000010,
    PH_OFS_HI = 7'b0000100,
    PH_OFS_LO = 7'b0001000,
    PH_TYPE   = 7'b0010000,
    PH_DATA   = 7'b0100000,
    PH_CSUM   = 7'b1000000
  } phase_t;

  typedef enum logic {
    KIND_DATA = 1'b0,
    KIND_END  = 1'b1
  } result_kind_t;

  typedef struct packed {
    byte_class_t cls;
    logic [7:0]  value;
  } byte_item_t;

  function automatic logic [7:0] digit_value(input logic [7:0] c);
    logic [7:0] v;
    if (c < CHAR_UPPER_A) begin
      v = c - DIGIT_OFS_LOW;
    end else begin
      v = c - DIGIT_OFS_HIGH;
    end
    return v;
  endfunction

endpackage

// ----- hdl/hex_record_parser_unit.sv -----
`timescale 1ns / 1ps
// Hex record parser, top level: one ASCII character per input transaction,
// one data byte or record-end per output transaction. Depends on hrp_pkg,
// hrp_front, hrp_queue and hrp_back.
//
// The block takes one character every clock cycle while the output keeps up;
// characters outside a record are dropped until a colon starts one. A pair of
// characters forms one byte; after its second character is accepted, each data
// byte or record end passes through a queue entry and then the output register
// before its output transaction can complete. The front end sets the rate: it
// pairs one character per cycle and pushes classified bytes into a two-entry
// queue, which absorbs output stalls; input ready drops only when that queue is
// full. The checksum is passed out with the record end and not verified.
module hex_record_parser_unit
  import hrp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] character
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [7:0] value, [23:8] address, [31:24] record_type,
                                  // [39:32] record_length, [47:40] data_index
  output logic        out_tuser   // [0] kind
);

  logic         push;
  byte_item_t   push_item;
  logic         q_full;
  logic         q_not_empty;
  byte_item_t   head_item;
  logic         pop;
  result_kind_t res_kind;
  logic [7:0]   res_value;
  logic [15:0]  res_address;
  logic [7:0]   res_type;
  logic [7:0]   res_length;
  logic [7:0]   res_index;

  hrp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .char_valid (in_tvalid),
    .char_data  (in_tdata),
    .queue_full (q_full),
    .char_ready (in_tready),
    .push       (push),
    .push_item  (push_item)
  );

  hrp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head_item (head_item)
  );

  hrp_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_valid  (q_not_empty),
    .item        (head_item),
    .pop         (pop),
    .res_ready   (out_tready),
    .res_valid   (out_tvalid),
    .res_kind    (res_kind),
    .res_value   (res_value),
    .res_address (res_address),
    .res_type    (res_type),
    .res_length  (res_length),
    .res_index   (res_index)
  );

  assign out_tdata = {res_index, res_length, res_type, res_address, res_value};
  assign out_tuser = res_kind;

endmodule

// ----- hdl/hrp_front.sv -----
`timescale 1ns / 1ps
// Front end: colon search, character pairing and field classification.
// Depends on hrp_pkg; feeds classified bytes into hrp_queue.
module hrp_front
  import hrp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       char_valid,
  input  logic [7:0] char_data,
  input  logic       queue_full,
  output logic       char_ready,
  output logic       push,
  output byte_item_t push_item
);

  phase_t     phase_r, phase_nxt;
  logic       half_r, half_nxt;
  logic [3:0] high_r, high_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic [7:0] digit;
  logic [7:0] byte_val;
  logic [7:0] cnt_inc;
  logic       accept;

  assign char_ready = !queue_full;
  assign accept     = char_valid && char_ready;
  assign digit      = digit_value(char_data);
  assign byte_val   = {high_r, 4'h0} | digit;
  assign cnt_inc    = cnt_r + 8'd1;

  always_comb begin
    phase_nxt       = phase_r;
    half_nxt        = half_r;
    high_nxt        = high_r;
    len_nxt         = len_r;
    cnt_nxt         = cnt_r;
    push            = 1'b0;
    push_item.value = byte_val;
    push_item.cls   = BC_LEN;
    if (accept) begin
      if (phase_r == PH_IDLE) begin
        if (char_data == CHAR_COLON) begin
          phase_nxt = PH_LEN;
          half_nxt  = 1'b0;
          cnt_nxt   = 8'd0;
        end
      end else if (!half_r) begin
        high_nxt = digit[3:0];
        half_nxt = 1'b1;
      end else begin
        half_nxt = 1'b0;
        push     = 1'b1;
        case (phase_r)
          PH_LEN: begin
            push_item.cls = BC_LEN;
            len_nxt       = byte_val;
            phase_nxt     = PH_OFS_HI;
          end
          PH_OFS_HI: begin
            push_item.cls = BC_OFS_HI;
            phase_nxt     = PH_OFS_LO;
          end
          PH_OFS_LO: begin
            push_item.cls = BC_OFS_LO;
            phase_nxt     = PH_TYPE;
          end
          PH_TYPE: begin
            push_item.cls = BC_TYPE;
            phase_nxt     = (len_r == 8'd0) ? PH_CSUM : PH_DATA;
          end
          PH_DATA: begin
            push_item.cls = BC_DATA;
            cnt_nxt       = cnt_inc;
            if (cnt_inc >= len_r) begin
              phase_nxt = PH_CSUM;
            end
          end
          PH_CSUM: begin
            push_item.cls = BC_CSUM;
            phase_nxt     = PH_IDLE;
          end
          default: begin
            push      = 1'b0;
            phase_nxt = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      half_r  <= 1'b0;
      high_r  <= 4'h0;
      len_r   <= 8'd0;
      cnt_r   <= 8'd0;
    end else begin
      phase_r <= phase_nxt;
      half_r  <= half_nxt;
      high_r  <= high_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  a_idle_no_half: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> !half_r)
    else $error("front holds a half byte while idle");

  a_push_on_pair: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> accept && half_r)
    else $error("byte pushed without a completed character pair");

  a_data_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> cnt_r < len_r)
    else $error("data count reached record length inside data phase");

endmodule

// ----- hdl/hrp_queue.sv -----
`timescale 1ns / 1ps
// Two-entry queue of classified bytes between front and back end.
// Depends on hrp_pkg.
module hrp_queue
  import hrp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  byte_item_t push_item,
  input  logic       pop,
  output logic       full,
  output logic       not_empty,
  output byte_item_t head_item
);

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  byte_item_t          mem_r [QUEUE_DEPTH];
  logic [PtrW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0]     count_r;
  logic                do_push, do_pop;

  assign full      = (count_r == CntW'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head_item = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CntW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("push into full queue");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(QUEUE_DEPTH))
    else $error("queue count out of range");

  a_pop_frees: assert property (@(posedge clk) disable iff (!rst_n)
    full && pop |=> !full)
    else $error("pop from full queue did not free an entry");

endmodule

// ----- hdl/hrp_back.sv -----
`timescale 1ns / 1ps
// Back end: holds record header fields and forms result transactions.
// Depends on hrp_pkg; drains hrp_queue into the output register.
module hrp_back
  import hrp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         item_valid,
  input  byte_item_t   item,
  output logic         pop,
  input  logic         res_ready,
  output logic         res_valid,
  output result_kind_t res_kind,
  output logic [7:0]   res_value,
  output logic [15:0]  res_address,
  output logic [7:0]   res_type,
  output logic [7:0]   res_length,
  output logic [7:0]   res_index
);

  logic [7:0]   len_r;
  logic [15:0]  ofs_r;
  logic [7:0]   type_r;
  logic [7:0]   idx_r;
  logic         out_valid_r;
  result_kind_t kind_r;
  logic [7:0]   value_r;
  logic [15:0]  addr_r;
  logic [7:0]   otype_r;
  logic [7:0]   olen_r;
  logic [7:0]   oidx_r;

  assign pop         = item_valid && (!out_valid_r || res_ready);
  assign res_valid   = out_valid_r;
  assign res_kind    = kind_r;
  assign res_value   = value_r;
  assign res_address = addr_r;
  assign res_type    = otype_r;
  assign res_length  = olen_r;
  assign res_index   = oidx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= 8'd0;
      ofs_r       <= 16'd0;
      type_r      <= 8'd0;
      idx_r       <= 8'd0;
      out_valid_r <= 1'b0;
      kind_r      <= KIND_DATA;
    end else begin
      if (pop && (item.cls == BC_DATA || item.cls == BC_CSUM)) begin
        out_valid_r <= 1'b1;
      end else if (res_ready) begin
        out_valid_r <= 1'b0;
      end
      if (pop) begin
        case (item.cls)
          BC_LEN: begin
            len_r <= item.value;
            idx_r <= 8'd0;
          end
          BC_OFS_HI: begin
            ofs_r <= {item.value, 8'h00};
          end
          BC_OFS_LO: begin
            ofs_r <= {ofs_r[15:8], item.value};
          end
          BC_TYPE: begin
            type_r <= item.value;
          end
          BC_DATA: begin
            kind_r <= KIND_DATA;
            idx_r  <= idx_r + 8'd1;
          end
          BC_CSUM: begin
            kind_r <= KIND_END;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && (item.cls == BC_DATA || item.cls == BC_CSUM)) begin
      value_r <= item.value;
      otype_r <= type_r;
      olen_r  <= len_r;
      if (item.cls == BC_DATA) begin
        addr_r <= ofs_r + {8'h00, idx_r};
        oidx_r <= idx_r;
      end else begin
        addr_r <= ofs_r;
        oidx_r <= 8'd0;
      end
    end
  end

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    pop && (item.cls == BC_DATA || item.cls == BC_CSUM) |=> out_valid_r)
    else $error("result byte popped without a result");

  a_end_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && kind_r == KIND_END |-> oidx_r == 8'd0)
    else $error("record end carries nonzero data index");

  a_data_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && kind_r == KIND_DATA |-> oidx_r < olen_r)
    else $error("data index beyond record length");

endmodule

// ----- tb/hex_record_parser_unit_tb.sv -----
`timescale 1ns / 1ps
// Testbench for hex_record_parser_unit: streams hex text characters in, predicts
// data-byte and record-end results, checks each output transaction in order.
// Depends on hrp_pkg and hex_record_parser_unit.
module hex_record_parser_unit_tb;
  import hrp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEMS_PER_PHASE = 180;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [7:0] ch;
    logic       drain;
  } char_item_t;

  typedef struct packed {
    result_kind_t kind;
    logic [7:0]   value;
    logic [15:0]  address;
    logic [7:0]   record_type;
    logic [7:0]   record_length;
    logic [7:0]   data_index;
  } parsed_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;
  logic        out_tuser;

  char_item_t     pending_chars[$];
  parsed_result_t expected_results[$];
  char_item_t     next_item;
  parsed_result_t oldest;

  int  sender_idle_pct;
  int  receiver_idle_pct;
  int  chars_pushed;
  int  chars_accepted;
  int  mismatch_count;
  int  cycle_count;
  int  phase_target;
  bit  in_accepted;
  bit  drain_next;

  // Parser state mirror
  phase_t      parse_phase;
  bit          half_held;
  logic [7:0]  high_part;
  logic [7:0]  rec_length;
  logic [15:0] rec_offset;
  logic [7:0]  rec_type;
  logic [7:0]  data_count;

  hex_record_parser_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic logic [7:0] char_to_digit(input logic [7:0] c);
    if (c < CHAR_UPPER_A) begin
      return c - DIGIT_OFS_LOW;
    end
    return c - DIGIT_OFS_HIGH;
  endfunction

  function automatic logic [7:0] nibble_char(input logic [3:0] n);
    if (n < 4'd10) begin
      return DIGIT_OFS_LOW + n;
    end
    return DIGIT_OFS_HIGH + n;
  endfunction

  task automatic decode_character(input logic [7:0] c);
    logic [7:0]     b;
    parsed_result_t r;
    if (parse_phase == PH_IDLE) begin
      if (c == CHAR_COLON) begin
        parse_phase = PH_LEN;
        half_held   = 1'b0;
        high_part   = '0;
        rec_length  = '0;
        rec_offset  = '0;
        rec_type    = '0;
        data_count  = '0;
      end
    end else if (!half_held) begin
      high_part = char_to_digit(c);
      half_held = 1'b1;
    end else begin
      half_held = 1'b0;
      b = {high_part[3:0], 4'b0000} | char_to_digit(c);
      case (parse_phase)
        PH_LEN: begin
          rec_length  = b;
          parse_phase = PH_OFS_HI;
        end
        PH_OFS_HI: begin
          rec_offset  = {b, 8'h00};
          parse_phase = PH_OFS_LO;
        end
        PH_OFS_LO: begin
          rec_offset  = {rec_offset[15:8], b};
          parse_phase = PH_TYPE;
        end
        PH_TYPE: begin
          rec_type    = b;
          parse_phase = (rec_length == 8'd0) ? PH_CSUM : PH_DATA;
        end
        PH_DATA: begin
          r.kind          = KIND_DATA;
          r.value         = b;
          r.address       = rec_offset + {8'h00, data_count};
          r.record_type   = rec_type;
          r.record_length = rec_length;
          r.data_index    = data_count;
          expected_results.push_back(r);
          data_count = data_count + 8'd1;
          if (data_count >= rec_length) begin
            parse_phase = PH_CSUM;
          end
        end
        default: begin
          r.kind          = KIND_END;
          r.value         = b;
          r.address       = rec_offset;
          r.record_type   = rec_type;
          r.record_length = rec_length;
          r.data_index    = 8'd0;
          expected_results.push_back(r);
          parse_phase = PH_IDLE;
        end
      endcase
    end
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch %s: got %0h, expected %0h (cycle %0d)", what, got, want, cycle_count);
    mismatch_count++;
  endtask

  task automatic push_char(input logic [7:0] c);
    char_item_t it;
    it.ch    = c;
    it.drain = drain_next;
    drain_next = 1'b0;
    pending_chars.push_back(it);
    chars_pushed++;
  endtask

  task automatic push_hex_byte(input logic [7:0] b);
    push_char(nibble_char(b[7:4]));
    push_char(nibble_char(b[3:0]));
  endtask

  task automatic push_record(input int len, input logic [15:0] ofs, input logic [7:0] typ);
    int i;
    push_char(CHAR_COLON);
    push_hex_byte(len[7:0]);
    push_hex_byte(ofs[15:8]);
    push_hex_byte(ofs[7:0]);
    push_hex_byte(typ);
    for (i = 0; i < len; i++) begin
      push_hex_byte(8'($urandom_range(0, 255)));
    end
    push_hex_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic push_random_stretch(input int target);
    int shape;
    int len;
    int i;
    logic [15:0] ofs;
    while (chars_pushed < target) begin
      shape = $urandom_range(0, 99);
      if (shape < 8) begin
        // idle noise between records
        len = $urandom_range(1, 4);
        for (i = 0; i < len; i++) begin
          push_char(8'($urandom_range(0, 255)));
        end
      end else if (shape < 20) begin
        // broken record: arbitrary bytes after the colon
        push_char(CHAR_COLON);
        len = $urandom_range(2, 30);
        for (i = 0; i < len; i++) begin
          push_char(8'($urandom_range(0, 255)));
        end
      end else begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
        ofs = ($urandom_range(0, 3) == 0) ? 16'(16'hFFFF - $urandom_range(0, 4))
                                          : 16'($urandom_range(0, 65535));
        push_record(len, ofs, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic wait_all_accepted();
    while (chars_accepted != chars_pushed) begin
      @(posedge clk);
    end
  endtask

  // Sender: hold a presented character until it is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_accepted) begin
      if (pending_chars.size() != 0
          && !(pending_chars[0].drain && expected_results.size() != 0)
          && $urandom_range(0, 99) >= sender_idle_pct) begin
        next_item = pending_chars.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= next_item.ch;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
    end
  end

  // Monitor: predict on input transactions, check output transactions
  always @(posedge clk) begin
    in_accepted = rst_n && in_tvalid && in_tready;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, address", out_tdata[23:8], 16'h0000);
      end else begin
        oldest = expected_results.pop_front();
        if (out_tuser !== oldest.kind)
          report_mismatch("kind", {15'd0, out_tuser}, {15'd0, oldest.kind});
        if (out_tdata[7:0] !== oldest.value)
          report_mismatch("value", {8'd0, out_tdata[7:0]}, {8'd0, oldest.value});
        if (out_tdata[23:8] !== oldest.address)
          report_mismatch("address", out_tdata[23:8], oldest.address);
        if (out_tdata[31:24] !== oldest.record_type)
          report_mismatch("record_type", {8'd0, out_tdata[31:24]}, {8'd0, oldest.record_type});
        if (out_tdata[39:32] !== oldest.record_length)
          report_mismatch("record_length", {8'd0, out_tdata[39:32]},
                          {8'd0, oldest.record_length});
        if (out_tdata[47:40] !== oldest.data_index)
          report_mismatch("data_index", {8'd0, out_tdata[47:40]}, {8'd0, oldest.data_index});
      end
    end
    if (in_accepted) begin
      decode_character(in_tdata);
      chars_accepted++;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    rst_n             = 1'b0;
    in_tvalid         = 1'b0;
    in_tdata          = 8'h00;
    out_tready        = 1'b0;
    in_accepted       = 1'b0;
    drain_next        = 1'b0;
    chars_pushed      = 0;
    chars_accepted    = 0;
    mismatch_count    = 0;
    cycle_count       = 0;
    phase_target      = 0;
    parse_phase       = PH_IDLE;
    half_held         = 1'b0;
    high_part         = '0;
    rec_length        = '0;
    rec_offset        = '0;
    rec_type          = '0;
    data_count        = '0;
    sender_idle_pct   = 27;
    receiver_idle_pct = 81;

    // ignored while idle
    push_char(8'h00);
    push_char(8'hFF);
    // zero length: checksum straight after the type
    push_record(0, 16'hFFFF, 8'h01);
    // offset wraps; colon and non-hex characters decoded as digits
    push_char(CHAR_COLON);
    push_hex_byte(8'h02);
    push_hex_byte(8'hFF);
    push_hex_byte(8'hFF);
    push_hex_byte(8'h00);
    push_char(CHAR_COLON);
    push_char(8'hFF);
    push_hex_byte(8'h7E);
    push_char(8'h00);
    push_char(8'h80);

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    push_random_stretch(ITEMS_PER_PHASE);
    wait_all_accepted();

    sender_idle_pct   = 81;
    receiver_idle_pct = 27;
    drain_next        = 1'b1;
    push_random_stretch(chars_pushed + ITEMS_PER_PHASE);
    wait_all_accepted();

    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    drain_next        = 1'b1;
    phase_target      = chars_pushed + ITEMS_PER_PHASE;
    push_record(255, 16'hFF80, 8'h00);
    push_random_stretch(phase_target);
    wait_all_accepted();

    while (expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
